// ----- rtl/core/mbsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mbsp_pkg;

    // Message kinds reported on the result channel
    localparam logic [3:0] KIND_CLOCK     = 4'd0;
    localparam logic [3:0] KIND_START     = 4'd1;
    localparam logic [3:0] KIND_CONTINUE  = 4'd2;
    localparam logic [3:0] KIND_STOP      = 4'd3;
    localparam logic [3:0] KIND_SONG_POS  = 4'd4;
    localparam logic [3:0] KIND_PROGRAM   = 4'd5;
    localparam logic [3:0] KIND_NOTE_ON   = 4'd6;
    localparam logic [3:0] KIND_NOTE_OFF  = 4'd7;
    localparam logic [3:0] KIND_CONTROL   = 4'd8;

    // Status bytes
    localparam logic [7:0] ST_NONE        = 8'h00;
    localparam logic [7:0] ST_RT_FIRST    = 8'hF8;
    localparam logic [7:0] ST_CLOCK       = 8'hF8;
    localparam logic [7:0] ST_START       = 8'hFA;
    localparam logic [7:0] ST_CONTINUE    = 8'hFB;
    localparam logic [7:0] ST_STOP        = 8'hFC;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SYS_FIRST   = 8'hF0;

    // Channel voice status high nibbles
    localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
    localparam logic [3:0] HI_NOTE_ON     = 4'h9;
    localparam logic [3:0] HI_CONTROL     = 4'hB;
    localparam logic [3:0] HI_PROGRAM     = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] HI_SYSTEM      = 4'hF;

    localparam int TDATA_W = 32;
    localparam int TUSER_W = 8;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic [7:0] running_status;
        logic [6:0] first_data;
        logic       have_first;
    } parse_state_t;

    // One decoded message
    typedef struct packed {
        logic        valid;
        logic [3:0]  msg_kind;
        logic [3:0]  channel;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [13:0] song_position;
    } parse_msg_t;

endpackage

`default_nettype wire

// ----- rtl/core/mbsp_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbsp_decode (
    input  wire logic [7:0]            rx_byte,
    input  wire mbsp_pkg::parse_state_t state_cur,
    output mbsp_pkg::parse_state_t      state_nxt,
    output mbsp_pkg::parse_msg_t        msg
);
    import mbsp_pkg::*;

    logic [3:0] hi;
    logic [3:0] chan;

    assign hi   = state_cur.running_status[7:4];
    assign chan = state_cur.running_status[3:0];

    // Byte classification, state update and message build
    always_comb
    begin
        state_nxt = state_cur;
        msg       = '0;

        if (rx_byte >= ST_RT_FIRST)
        begin
            // real-time: never touches the parse
            case (rx_byte)
                ST_CLOCK:
                begin
                    msg.valid    = 1'b1;
                    msg.msg_kind = KIND_CLOCK;
                end
                ST_START:
                begin
                    msg.valid    = 1'b1;
                    msg.msg_kind = KIND_START;
                end
                ST_CONTINUE:
                begin
                    msg.valid    = 1'b1;
                    msg.msg_kind = KIND_CONTINUE;
                end
                ST_STOP:
                begin
                    msg.valid    = 1'b1;
                    msg.msg_kind = KIND_STOP;
                end
                default:
                begin
                    msg.valid = 1'b0;
                end
            endcase
        end
        else if (rx_byte[7])
        begin
            // status byte
            if (rx_byte == ST_SONG_POS)
            begin
                state_nxt.running_status = ST_SONG_POS;
                state_nxt.have_first     = 1'b0;
            end
            else if (rx_byte >= ST_SYS_FIRST)
            begin
                // other system common: pending first byte is left alone
                state_nxt.running_status = ST_NONE;
            end
            else
            begin
                state_nxt.running_status = rx_byte;
                state_nxt.have_first     = 1'b0;
            end
        end
        else if (state_cur.running_status == ST_SONG_POS)
        begin
            // song position pointer: LSB then MSB
            if (!state_cur.have_first)
            begin
                state_nxt.first_data = rx_byte[6:0];
                state_nxt.have_first = 1'b1;
            end
            else
            begin
                state_nxt.running_status = ST_NONE;
                state_nxt.have_first     = 1'b0;
                msg.valid                = 1'b1;
                msg.msg_kind             = KIND_SONG_POS;
                msg.song_position        = {rx_byte[6:0], state_cur.first_data};
            end
        end
        else if (state_cur.running_status != ST_NONE && hi != HI_CHAN_PRESS)
        begin
            if (hi == HI_PROGRAM)
            begin
                msg.valid    = 1'b1;
                msg.msg_kind = KIND_PROGRAM;
                msg.channel  = chan;
                msg.data_one = rx_byte[6:0];
            end
            else if (!state_cur.have_first)
            begin
                state_nxt.first_data = rx_byte[6:0];
                state_nxt.have_first = 1'b1;
            end
            else
            begin
                state_nxt.have_first = 1'b0;
                msg.channel          = chan;
                msg.data_one         = state_cur.first_data;
                msg.data_two         = rx_byte[6:0];
                // poly pressure and pitch bend pairs give nothing
                case (hi)
                    HI_NOTE_ON:
                    begin
                        msg.valid    = 1'b1;
                        msg.msg_kind = (rx_byte[6:0] == 7'd0) ? KIND_NOTE_OFF
                                                              : KIND_NOTE_ON;
                    end
                    HI_NOTE_OFF:
                    begin
                        msg.valid    = 1'b1;
                        msg.msg_kind = KIND_NOTE_OFF;
                    end
                    HI_CONTROL:
                    begin
                        msg.valid    = 1'b1;
                        msg.msg_kind = KIND_CONTROL;
                    end
                    default:
                    begin
                        msg.valid = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/midi_byte_stream_parser_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// MIDI byte stream parser with running status. Each byte taken on the s_axis
// side passes through an input register, is decoded combinationally against
// the running status, and any resulting message lands in the output register
// for m_axis; the byte-to-byte state (running status, first data byte and its
// flag) is updated in that same decode cycle. A byte is accepted every clock
// while the result side keeps up, and its result is valid on m_axis once it
// has passed the input register and then the output register; throughput is
// set by the single decode stage. Bytes that give no message
// (status bytes, first data bytes, ignored real-time bytes) produce nothing
// on m_axis. Results carry the message kind in m_axis_tuser and the message
// fields in m_axis_tdata.
module midi_byte_stream_parser_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [3:0] channel, [10:4] data_one, [17:11] data_two, [31:18] song_position
    output logic [mbsp_pkg::TDATA_W-1:0]        m_axis_tdata,
    // [3:0] msg_kind, [7:4] zero
    output logic [mbsp_pkg::TUSER_W-1:0]        m_axis_tuser
);
    import mbsp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_msg_t   msg;
    logic         out_valid_reg;
    parse_msg_t   out_msg_reg;
    logic         out_free;
    logic         fire;

    // Stage handshake: decode when the result slot is free or draining
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Decode
    mbsp_decode u_decode (
        .rx_byte   (in_byte_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .msg       (msg)
    );

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && msg.valid)
        begin
            out_msg_reg <= msg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_msg_reg.song_position, out_msg_reg.data_two,
                            out_msg_reg.data_one, out_msg_reg.channel};
    assign m_axis_tuser  = {4'd0, out_msg_reg.msg_kind};

`ifndef SYNTHESIS
    // running status is none, song position, or a channel voice status
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.running_status == ST_NONE ||
        state_reg.running_status == ST_SONG_POS ||
        (state_reg.running_status[7] && state_reg.running_status[7:4] != HI_SYSTEM))
        else $error("running status holds an illegal value");

    // no kind beyond control change is ever presented
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[3:0] <= KIND_CONTROL))
        else $error("result kind out of range");

    // real-time and song position results carry no channel
    a_sys_no_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3:0] <= KIND_SONG_POS) |->
            (m_axis_tdata[3:0] == 4'd0))
        else $error("system message carries a channel");

    // a byte that decodes to a message with a free slot shows up next cycle
    a_msg_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && msg.valid) |=> m_axis_tvalid)
        else $error("decoded message lost");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_midi_byte_stream_parser_top.sv -----
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser_top;

    import mbsp_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int TAIL_CYCLES   = 8;
    localparam int RANDOM_ITEMS  = 780;
    localparam int RANDOM_SEGS   = 4;

    // Channel voice kinds that are consumed without a message
    localparam logic [3:0] HI_POLY_PRESS = 4'hA;
    localparam logic [3:0] HI_PITCH_BEND = 4'hE;

    typedef logic [7:0] byte_q_t[$];

    // One decoded MIDI message as it should appear on the result side
    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [13:0] song_pos;
    } exp_msg_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0] m_axis_tuser;

    // Parser state as the byte stream should leave it
    logic [7:0]  run_status;
    logic [6:0]  held_data;
    logic        held_valid;

    exp_msg_t    pending_msgs[$];
    int          error_count;
    int          cycle_count;
    int          bytes_sent;
    int          burst_left;
    bit          gaps_on;
    rx_mode_t    rx_mode;
    int          hold_off_cycles;
    logic [7:0]  stall_pattern;
    logic [7:0]  last_voice_status;

    midi_byte_stream_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_midi_byte_stream_parser_top: done, errors");
            $finish;
        end
    end

    function automatic void push_msg(input logic [3:0] kind, input logic [3:0] chan,
                                     input logic [6:0] d1, input logic [6:0] d2,
                                     input logic [13:0] pos);
        exp_msg_t m;
        m.kind     = kind;
        m.channel  = chan;
        m.data_one = d1;
        m.data_two = d2;
        m.song_pos = pos;
        pending_msgs.push_back(m);
    endfunction

    // Advance the parser state by one accepted byte and queue any message it gives
    function automatic void decode_midi_byte(input logic [7:0] b);
        logic [3:0] hi;
        logic [3:0] chan;
        hi   = run_status[7:4];
        chan = run_status[3:0];
        if (b >= ST_RT_FIRST)
        begin
            // real-time: state untouched, unused codes dropped
            case (b)
                ST_CLOCK:    push_msg(KIND_CLOCK, 4'd0, 7'd0, 7'd0, 14'd0);
                ST_START:    push_msg(KIND_START, 4'd0, 7'd0, 7'd0, 14'd0);
                ST_CONTINUE: push_msg(KIND_CONTINUE, 4'd0, 7'd0, 7'd0, 14'd0);
                ST_STOP:     push_msg(KIND_STOP, 4'd0, 7'd0, 7'd0, 14'd0);
                default: ;
            endcase
        end
        else if (b[7])
        begin
            if (b == ST_SONG_POS)
            begin
                run_status = ST_SONG_POS;
                held_valid = 1'b0;
            end
            else if (b >= ST_SYS_FIRST)
            begin
                // other system common: held byte flag deliberately kept
                run_status = ST_NONE;
            end
            else
            begin
                run_status = b;
                held_valid = 1'b0;
            end
        end
        else if (run_status == ST_SONG_POS)
        begin
            if (!held_valid)
            begin
                held_data  = b[6:0];
                held_valid = 1'b1;
            end
            else
            begin
                run_status = ST_NONE;
                held_valid = 1'b0;
                push_msg(KIND_SONG_POS, 4'd0, 7'd0, 7'd0, {b[6:0], held_data});
            end
        end
        else if (run_status != ST_NONE)
        begin
            if (hi == HI_PROGRAM)
                push_msg(KIND_PROGRAM, chan, b[6:0], 7'd0, 14'd0);
            else if (hi != HI_CHAN_PRESS)
            begin
                if (!held_valid)
                begin
                    held_data  = b[6:0];
                    held_valid = 1'b1;
                end
                else
                begin
                    held_valid = 1'b0;
                    case (hi)
                        HI_NOTE_ON:
                            push_msg((b[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON,
                                     chan, held_data, b[6:0], 14'd0);
                        HI_NOTE_OFF:
                            push_msg(KIND_NOTE_OFF, chan, held_data, b[6:0], 14'd0);
                        HI_CONTROL:
                            push_msg(KIND_CONTROL, chan, held_data, b[6:0], 14'd0);
                        default: ;  // poly pressure, pitch bend
                    endcase
                end
            end
        end
    endfunction

    // Receiver: stall pattern per mode, with an optional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        stall_pattern = 8'b1011_0110;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) < 65);
                    default:    m_axis_tready <= stall_pattern[0];
                endcase
                stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        exp_msg_t m;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_msgs.size() == 0)
            begin
                $display("%0t: unexpected message, expected none, got tuser %0h tdata %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                m = pending_msgs.pop_front();
                check_field("msg_kind", m.kind, m_axis_tuser[3:0]);
                check_field("tuser pad", 0, m_axis_tuser[7:4]);
                check_field("channel", m.channel, m_axis_tdata[3:0]);
                check_field("data_one", m.data_one, m_axis_tdata[10:4]);
                check_field("data_two", m.data_two, m_axis_tdata[17:11]);
                check_field("song_position", m.song_pos, m_axis_tdata[31:18]);
            end
        end
    end

    // Offer one byte from a falling edge, return at the falling edge after it is taken
    task automatic send_item(input logic [7:0] b);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_midi_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic play_bytes(input byte_q_t seq);
        foreach (seq[i])
            send_item(seq[i]);
    endtask

    // Sender pause until every queued message has come out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic test_realtime_bytes();
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        play_bytes('{ST_START, ST_CONTINUE, ST_STOP, 8'hF9, 8'hFF});
        wait_for_results();
    endtask

    task automatic test_channel_voice();
        rx_mode = RX_PATTERN;
        // note on extremes, then running status with a clock inside and velocity zero
        play_bytes('{8'h9F, 8'h00, 8'h7F, 8'h7F, ST_CLOCK, 8'h00});
        play_bytes('{8'h80, 8'h12, 8'h34});
        // control change, then a system common byte cuts the next one short
        play_bytes('{8'hB7, 8'h07, 8'h64, 8'h05, ST_SYS_FIRST, 8'h10});
        // program change, channel pressure, pitch bend
        play_bytes('{8'hC0, 8'h7F, 8'hD2, 8'h11, 8'hE3, 8'h00, 8'h40});
        wait_for_results();
    endtask

    task automatic test_song_position();
        rx_mode = RX_RANDOM;
        // full-scale position, then a data byte with no status left
        play_bytes('{ST_SONG_POS, 8'h7F, 8'h7F, 8'h55});
        wait_for_results();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        hold_off_cycles = 150;
        repeat (40)
            send_item(ST_CLOCK);
        wait_for_results();
    endtask

    task automatic send_random_message();
        int         pick;
        int         n_data;
        logic [3:0] hi;
        logic [7:0] status;
        logic [7:0] d;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            send_item(8'($urandom_range(0, 255)));
            last_voice_status = ST_NONE;
        end
        else if (pick < 12)
        begin
            // system common other than song position
            pick = $urandom_range(0, 6);
            send_item((pick < 2) ? 8'(ST_SYS_FIRST + pick) : 8'(ST_SYS_FIRST + pick + 1));
            last_voice_status = ST_NONE;
        end
        else if (pick < 20)
        begin
            send_item(ST_SONG_POS);
            repeat (2)
                send_item(8'($urandom_range(0, 127)));
            last_voice_status = ST_NONE;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                hi = HI_NOTE_ON;
            else if (pick < 45)
                hi = HI_NOTE_OFF;
            else if (pick < 65)
                hi = HI_CONTROL;
            else if (pick < 77)
                hi = HI_PROGRAM;
            else if (pick < 85)
                hi = HI_CHAN_PRESS;
            else if (pick < 92)
                hi = HI_POLY_PRESS;
            else
                hi = HI_PITCH_BEND;
            status = {hi, 4'($urandom_range(0, 15))};
            if (status == last_voice_status && $urandom_range(0, 99) < 35)
                status = last_voice_status;
            else
                status = {hi, 4'($urandom_range(0, 15))};
            // running status reuse skips the status byte
            if (status != last_voice_status || $urandom_range(0, 1) == 0)
                send_item(status);
            last_voice_status = status;
            hi = status[7:4];
            n_data = (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) ? 1 : 2;
            if ($urandom_range(0, 99) < 5)
                n_data--;
            for (int i = 0; i < n_data; i++)
            begin
                if ($urandom_range(0, 99) < 10)
                    send_item(8'($urandom_range(ST_RT_FIRST, 255)));
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    d = 8'h00;
                else if (pick < 20)
                    d = 8'h7F;
                else
                    d = 8'($urandom_range(0, 127));
                send_item(d);
            end
        end
    endtask

    task automatic test_random_stream();
        int target;
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            case (seg)
                0:       rx_mode = RX_RANDOM;
                1:       rx_mode = RX_PATTERN;
                default: rx_mode = RX_ALWAYS;
            endcase
            gaps_on = (seg != 2);
            target = bytes_sent + RANDOM_ITEMS / RANDOM_SEGS;
            while (bytes_sent < target)
                send_random_message();
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = 8'h00;
        run_status        = ST_NONE;
        held_data         = 7'd0;
        held_valid        = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        bytes_sent        = 0;
        burst_left        = 0;
        gaps_on           = 1'b1;
        rx_mode           = RX_ALWAYS;
        hold_off_cycles   = 0;
        last_voice_status = ST_NONE;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_realtime_bytes();
        test_channel_voice();
        test_song_position();
        test_backpressure();
        test_random_stream();

        wait_for_results();
        if (error_count == 0)
            $display("tb_midi_byte_stream_parser_top: done, clean");
        else
            $display("tb_midi_byte_stream_parser_top: done, errors");
        $finish;
    end

endmodule
